// ----- src/sliding_window_rate_meter_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window rate meter
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_METER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_METER_DEFINES_SVH

// Same-cycle implication under reset
`define SWRM_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication under reset
`define SWRM_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- src/swrm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swrm_pkg
// Widths, register codes and the divider step shared by the rate meter.
// ---------------------------------------------------------------------------
package swrm_pkg;

    localparam int DEPTH    = 128;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int TIME_W   = 32;
    localparam int BYTES_W  = 16;
    localparam int BITS_W   = BYTES_W + 3;
    localparam int TOTAL_W  = 26;
    localparam int MAXE_W   = 8;
    localparam int WIN_W    = 16;
    localparam int DIV_W    = WIN_W + 1;
    localparam int NUM_W    = TOTAL_W;
    localparam int FRATE_W  = 8;
    localparam int MS_PER_S = 1000;
    localparam int RESET_MAX_ENTRIES = 88;
    localparam int RESET_WINDOW_MS   = 1000;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 8'd1;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // One long-division lane: partial remainder and shifting dividend/quotient
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } div_lane_t;

    // Work handed from cell to cell
    typedef struct packed {
        logic [DIV_W-1:0] div;
        div_lane_t        b;
        div_lane_t        f;
    } div_work_t;

    // Produce one quotient bit of a lane
    function automatic div_lane_t lane_step(div_lane_t l, logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        div_lane_t      r;
        t    = {l.rem, l.nq[NUM_W-1]};
        r.nq = {l.nq[NUM_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            t       = t - {1'b0, d};
            r.nq[0] = 1'b1;
        end
        r.rem = t[DIV_W-1:0];
        return r;
    endfunction

    function automatic div_work_t div_step(div_work_t w);
        div_work_t r;
        r.div = w.div;
        r.b   = lane_step(w.b, w.div);
        r.f   = lane_step(w.f, w.div);
        return r;
    endfunction

endpackage

// ----- src/swrm_div_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swrm_div_cell
// One quotient bit of both rate divisions; passes its work to the next cell.
// ---------------------------------------------------------------------------
module swrm_div_cell
    import swrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  div_work_t in_work,
    output logic      out_valid,
    output div_work_t out_work
);

    logic      valid_reg;
    div_work_t work_reg;

    // Advance the valid marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Take one step only on new work, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid)
            work_reg <= div_step(in_work);
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ----- src/swrm_ring.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swrm_ring
// History ring of frame records: one write port, one registered read port.
// ---------------------------------------------------------------------------
module swrm_ring
    import swrm_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [TIME_W-1:0] wr_time,
    input  logic [BITS_W-1:0] wr_bits,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [TIME_W-1:0] rd_time,
    output logic [BITS_W-1:0] rd_bits
);

    logic [TIME_W-1:0] time_mem [DEPTH];
    logic [BITS_W-1:0] bits_mem [DEPTH];
    logic [TIME_W-1:0] rd_time_reg;
    logic [BITS_W-1:0] rd_bits_reg;

    // Write a new record
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_time;
            bits_mem[wr_addr] <= wr_bits;
        end
    end

    // Read the requested slot every cycle
    always_ff @(posedge clk)
    begin
        rd_time_reg <= time_mem[rd_addr];
        rd_bits_reg <= bits_mem[rd_addr];
    end

    assign rd_time = rd_time_reg;
    assign rd_bits = rd_bits_reg;

endmodule

// ----- src/sliding_window_rate_meter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_rate_meter
// Bit rate and frame rate over a sliding window of frame records.
// ---------------------------------------------------------------------------
// One request at a time. A record request reads the oldest slot of the ring,
// updates the totals and returns to idle. A query reads and checks the oldest
// record, dropping expired records one at a time, then passes through the
// row of divider cells (one quotient bit per cell) and loads the output
// register. The single read port of the ring sets the expiry pace. A new
// request is taken while a result waits in the output register; the next
// result waits until that one is taken.
module sliding_window_rate_meter
    import swrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // now_ms[31:0], frame_bytes[47:32]
    input  logic                  s_tuser,   // operation
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata    // bit_rate[25:0], frame_rate[33:26]
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_PUT  = 5'b10000
    } state_t;

    localparam int NCELL = NUM_W;

    state_t              state_reg, state_next;
    logic                op_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [MAXE_W-1:0]   max_entries_reg;
    logic [WIN_W-1:0]    window_reg;
    logic [ADDR_W-1:0]   newest_reg, newest_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                zero_reg, zero_next;
    logic                m_tvalid_reg;
    logic [39:0]         m_tdata_reg;

    logic [TIME_W-1:0]   rd_time;
    logic [BITS_W-1:0]   rd_bits;
    logic [ADDR_W-1:0]   oldest;
    logic [CNT_W-1:0]    limit;
    logic [TIME_W-1:0]   age;
    logic                expired;
    logic [DIV_W-1:0]    gap;
    logic [DIV_W-1:0]    fnum;
    logic [BITS_W-1:0]   new_bits;
    logic                wr_en;
    logic                load_out;
    logic [FRATE_W-1:0]  frate;

    logic                cell_valid [NCELL+1];
    div_work_t           cell_work  [NCELL+1];

    assign oldest   = newest_reg - count_reg[ADDR_W-1:0] + ADDR_W'(1);
    assign age      = now_reg - rd_time;
    assign expired  = age > TIME_W'(window_reg);
    assign gap      = {1'b0, age[WIN_W-1:0]} + DIV_W'(1);
    assign fnum     = DIV_W'(32'(count_reg) * 32'(MS_PER_S));
    assign new_bits = {bytes_reg, 3'b000};

    // Clamp the record limit to 1..DEPTH
    always_comb
    begin
        if (max_entries_reg == '0)
            limit = CNT_W'(1);
        else if (32'(max_entries_reg) > 32'(DEPTH))
            limit = CNT_W'(DEPTH);
        else
            limit = CNT_W'(max_entries_reg);
    end

    swrm_ring u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (newest_next),
        .wr_time (now_reg),
        .wr_bits (new_bits),
        .rd_addr (oldest),
        .rd_time (rd_time),
        .rd_bits (rd_bits)
    );

    // Feed the divider row
    assign cell_valid[0]     = (state_reg == ST_CHK) && (op_reg == OP_QUERY)
                               && (count_reg != '0) && !expired;
    assign cell_work[0].div  = gap;
    assign cell_work[0].b    = '{rem: '0, nq: total_reg};
    assign cell_work[0].f    = '{rem: '0, nq: NUM_W'(fnum)};

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        swrm_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_work   (cell_work[i]),
            .out_valid (cell_valid[i+1]),
            .out_work  (cell_work[i+1])
        );
    end

    // Sequence requests
    always_comb
    begin
        state_next  = state_reg;
        newest_next = newest_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        zero_next   = zero_reg;
        wr_en       = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_RD;
            end
            ST_RD:
                state_next = ST_CHK;
            ST_CHK:
            begin
                if (op_reg == OP_RECORD)
                begin
                    // drop the oldest record when full, then write the new one
                    newest_next = newest_reg + ADDR_W'(1);
                    wr_en       = 1'b1;
                    if (count_reg >= limit)
                        total_next = total_reg - TOTAL_W'(rd_bits) + TOTAL_W'(new_bits);
                    else
                    begin
                        total_next = total_reg + TOTAL_W'(new_bits);
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
                else if (count_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_PUT;
                end
                else if (expired)
                begin
                    total_next = total_reg - TOTAL_W'(rd_bits);
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RD;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cell_valid[NCELL])
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            newest_reg      <= '0;
            count_reg       <= '0;
            total_reg       <= '0;
            zero_reg        <= 1'b0;
            max_entries_reg <= MAXE_W'(RESET_MAX_ENTRIES);
            window_reg      <= WIN_W'(RESET_WINDOW_MS);
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            zero_reg   <= zero_next;
            if (cfg_valid && cfg_index == REG_MAX_ENTRIES)
                max_entries_reg <= cfg_data[MAXE_W-1:0];
            if (cfg_valid && cfg_index == REG_WINDOW_MS)
                window_reg <= cfg_data[WIN_W-1:0];
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser;
            now_reg   <= s_tdata[31:0];
            bytes_reg <= s_tdata[47:32];
        end
    end

    // Saturate the frame rate
    assign frate = (cell_work[NCELL].f.nq[NUM_W-1:FRATE_W] != '0)
                   ? {FRATE_W{1'b1}} : cell_work[NCELL].f.nq[FRATE_W-1:0];

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (zero_reg)
                m_tdata_reg <= '0;
            else
                m_tdata_reg <= {6'b0, frate, cell_work[NCELL].b.nq};
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

// ----- src/swrm_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swrm_checker
// Port-level checks of the rate meter, bound to the top level.
// ---------------------------------------------------------------------------
`include "sliding_window_rate_meter_defines.svh"

module swrm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result stays offered
    `SWRM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")

    // Padding bits of a result are zero
    `SWRM_ASSERT_NOW(a_out_pad, clk, rst_n, m_tvalid, m_tdata[39:34] == 6'b0, "result pad set")

    // One request at a time: no accept in the cycle after an accept
    `SWRM_ASSERT_NEXT(a_one_req, clk, rst_n, s_tvalid && s_tready, !s_tready, "back-to-back accept")

    // Config channel never stalls
    `SWRM_ASSERT_NOW(a_cfg_rdy, clk, rst_n, 1'b1, cfg_ready, "config stalled")

endmodule

bind sliding_window_rate_meter swrm_checker u_swrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ----- tb/tb_sliding_window_rate_meter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sliding_window_rate_meter
// Random and directed test of the sliding window rate meter. A local model
// of the frame history predicts the rates of each query; a scoreboard
// compares every result against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_sliding_window_rate_meter;
    import swrm_pkg::*;

    // Frame history model and queue of predicted rates
    class rate_scoreboard;
        logic [31:0] stamp_q[DEPTH];
        logic [18:0] bits_q[DEPTH];
        int unsigned head;
        int unsigned live;
        logic [25:0] total;
        logic [7:0]  limit_reg;
        logic [15:0] window_reg;
        logic [33:0] pending[$];
        int unsigned errors;

        function new();
            head = 0;
            live = 0;
            total = '0;
            limit_reg = 8'(RESET_MAX_ENTRIES);
            window_reg = 16'(RESET_WINDOW_MS);
            errors = 0;
        endfunction

        function int unsigned oldest();
            return (head + DEPTH - (live - 1)) % DEPTH;
        endfunction

        function void drop();
            total = total - 26'(bits_q[oldest()]);
            live--;
        endfunction

        function void set_reg(logic [7:0] idx, logic [15:0] val);
            if (idx == REG_MAX_ENTRIES)
                limit_reg = val[7:0];
            else if (idx == REG_WINDOW_MS)
                window_reg = val;
        endfunction

        // Note an accepted request
        function void note_request(logic op, logic [31:0] now, logic [15:0] nbytes);
            int unsigned lim;
            logic [31:0] age;
            logic [32:0] span;
            logic [25:0] br;
            longint unsigned fr;
            lim = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : limit_reg);
            if (op == OP_RECORD) begin
                if (live >= lim && live > 0)
                    drop();
                head = (head + 1) % DEPTH;
                stamp_q[head] = now;
                bits_q[head] = {nbytes, 3'b000};
                total = total + 26'({nbytes, 3'b000});
                live++;
            end
            else begin
                br = '0;
                fr = 0;
                while (live > 0) begin
                    age = now - stamp_q[oldest()];
                    if (age > 32'(window_reg))
                        drop();
                    else
                        break;
                end
                if (live > 0) begin
                    age = now - stamp_q[oldest()];
                    span = {1'b0, age} + 33'd1;
                    br = 26'(total / span);
                    fr = (live * 1000) / span;
                    if (fr > 255)
                        fr = 255;
                end
                pending.push_back({fr[7:0], br});
            end
        endfunction

        // Check one result against the oldest prediction
        function void check_result(logic [39:0] data);
            logic [33:0] exp_v;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", data);
                return;
            end
            exp_v = pending.pop_front();
            if (data[25:0] !== exp_v[25:0] || data[33:26] !== exp_v[33:26]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: bit_rate exp %0d got %0d, frame_rate exp %0d got %0d",
                             exp_v[25:0], data[25:0], exp_v[33:26], data[33:26]);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = 0;   // now_ms[31:0], frame_bytes[47:32]
    logic        s_tuser = 0;   // operation
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;       // bit_rate[25:0], frame_rate[33:26]

    rate_scoreboard sb = new();
    logic [31:0] clock_ms;
    int          hold_off;
    int          burst_left;

    sliding_window_rate_meter dut (.*);

    always #4 clk = ~clk;

    // Receiver: stall pattern plus long hold-off, check on accept
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Offer one request with burst/gap idling
    task automatic send(logic op, logic [31:0] now, logic [15:0] nbytes);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6))
            begin
                @(negedge clk);
                s_tvalid <= 0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {nbytes, now};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, now, nbytes);
    endtask

    task automatic go_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    // Random request: mostly records with advancing time, some queries
    task automatic random_request(int qpct, int step_max);
        logic [15:0] b;
        clock_ms = clock_ms + 32'($urandom_range(0, step_max));
        b = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
        if ($urandom_range(0, 99) < qpct)
            send(OP_QUERY, ($urandom_range(0, 30) == 0) ? $urandom : clock_ms, b);
        else
            send(OP_RECORD, ($urandom_range(0, 30) == 0) ? clock_ms + 32'd5 : clock_ms, b);
    endtask

    initial
    begin
        #20000000;
        $display("[sliding_window_rate_meter] ERROR");
        $finish;
    end

    initial
    begin
        hold_off = 0;
        burst_left = 0;
        clock_ms = 32'hFFFF_F000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Directed: empty query, extremes, future stamp, lowered limit
        send(OP_QUERY, 32'd0, 16'd0);
        send(OP_RECORD, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_QUERY, 32'hFFFF_FFFF, 16'd0);
        send(OP_RECORD, 32'd0, 16'd0);
        send(OP_QUERY, 32'd0, 16'hFFFF);
        send(OP_QUERY, 32'd999, 16'd0);
        send(OP_RECORD, 32'd2000, 16'd100);
        send(OP_QUERY, 32'd1500, 16'd0);
        send(OP_QUERY, 32'd3001, 16'd0);
        for (int i = 0; i < 6; i++)
            send(OP_RECORD, 32'd5000, 16'hFFFF);
        send(OP_QUERY, 32'd5000, 16'd0);
        go_idle();
        write_reg(REG_MAX_ENTRIES, 16'd2);
        write_reg(8'd7, 16'd3);
        send(OP_RECORD, 32'd5001, 16'd8);
        send(OP_QUERY, 32'd5001, 16'd0);
        go_idle();

        // Phases over register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_MAX_ENTRIES, 16'd0); write_reg(REG_WINDOW_MS, 16'd1); end
                1: begin
                    write_reg(REG_MAX_ENTRIES, 16'd128);
                    write_reg(REG_WINDOW_MS, 16'd65535);
                end
                2: begin
                    write_reg(REG_MAX_ENTRIES, 16'd255);
                    write_reg(REG_WINDOW_MS, 16'd200);
                end
                3: begin write_reg(REG_MAX_ENTRIES, 16'd1); write_reg(REG_WINDOW_MS, 16'd50); end
                default: begin
                    write_reg(REG_MAX_ENTRIES, 16'($urandom_range(0, 255)));
                    write_reg(REG_WINDOW_MS, 16'($urandom_range(1, 65535)));
                end
            endcase
            for (int n = 0; n < 240; n++)
            begin
                if (ph == 2 && n == 100)
                    hold_off = 400;
                random_request(20, (ph == 1) ? 2000 : 40);
            end
            go_idle();
        end

        go_idle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[sliding_window_rate_meter] OK");
        else
            $display("[sliding_window_rate_meter] ERROR");
        $finish;
    end
endmodule
